### rtl/ple_pkg.sv
package ple_pkg;

   // list geometry
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int FUNC_W  = 3;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INS_AT   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_HEAD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DEL_TAIL = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DEL_AT   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_DUMP     = 3'd6;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic exec;       // request beat accepted, run it
      logic dump_step;  // load next dump element into output register
   } ple_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // output register can take a beat this cycle
      logic dump_more;  // accepted request is a dump of two or more elements
      logic dump_last;  // next dump element is the final one
   } ple_sts_type;

endpackage

### rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to DEPTH signed 32-bit values.
// Request channel (req_*): one beat carries func, value and position; it
// inserts at head, tail or a 1-based position, deletes head, tail or a
// position, or dumps the list. Result channel (rsp_*): each beat carries
// status, element count after the request, element value/valid and last.
// Insert and delete requests give one result beat, which appears in the cycle
// after the request beat is accepted; the cell chain shifts at that edge. A
// dump of N elements gives N beats, one per cycle while unstalled, in element
// order from the head, last set on the final one; an empty dump gives one beat
// with status empty. Throughput is one request per cycle for insert/delete
// while unstalled; a dump blocks requests until its last beat is loaded, paced
// by the dump read counter that walks the cells one per cycle. A single output
// register holds each result beat; in idle, req_ready is high while it is
// empty or being taken. If the receiver stalls, the beat holds and req_ready
// drops until taken. Synchronous reset empties the list and drops rsp_valid.
module positional_list_engine
   import ple_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]        rsp_element_count,
   output logic signed [DATA_W-1:0]  rsp_element_value,
   output logic                      rsp_element_valid,
   output logic                      rsp_last
);

   ple_cmd_type cmd;
   ple_sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_element_value (rsp_element_value),
      .rsp_element_valid (rsp_element_valid),
      .rsp_last          (rsp_last)
   );

endmodule

### rtl/ple_ctrl.sv
module ple_ctrl
   import ple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ple_sts_type sts,
   output ple_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic state_ff;
   logic state_in;

   // handshake and commands
   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && sts.out_free;
      cmd.exec      = req_valid && req_ready;
      cmd.dump_step = (state_ff == ST_DUMP) && sts.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.exec && sts.dump_more) state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (cmd.dump_step && sts.dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ple_dpath.sv
module ple_dpath
   import ple_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ple_cmd_type               cmd,
   output ple_sts_type               sts,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]        rsp_element_count,
   output logic signed [DATA_W-1:0]  rsp_element_value,
   output logic                      rsp_element_valid,
   output logic                      rsp_last
);

   // cell chain and count
   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [DATA_W-1:0] cells_in [DEPTH];
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;

   // output register
   logic                rsp_valid_ff,   rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff,  rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff,   rsp_count_in;
   logic [DATA_W-1:0]   rsp_value_ff,   rsp_value_in;
   logic                rsp_evalid_ff,  rsp_evalid_in;
   logic                rsp_last_ff,    rsp_last_in;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] fill_ext;
   logic [CNT_W-1:0] pos_idx;
   logic [CNT_W-1:0] ins_idx;
   logic [CNT_W-1:0] del_idx;
   logic             is_ins;
   logic             is_del;
   logic             is_full;
   logic             is_empty;
   logic             ins_bad;
   logic             del_bad;
   logic             do_ins;
   logic             do_del;
   logic [STAT_W-1:0] op_status;

   // request decode and checks
   always_comb begin
      pos_ext  = CMP_W'(req_position);
      fill_ext = CMP_W'(fill_ff);
      pos_idx  = CNT_W'(pos_ext - CMP_W'(1));
      is_full  = (fill_ff == CNT_W'(DEPTH));
      is_empty = (fill_ff == '0);
      is_ins   = (req_func == FUNC_INS_HEAD) || (req_func == FUNC_INS_TAIL) ||
                 (req_func == FUNC_INS_AT);
      is_del   = (req_func == FUNC_DEL_HEAD) || (req_func == FUNC_DEL_TAIL) ||
                 (req_func == FUNC_DEL_AT);
      ins_bad  = (req_func == FUNC_INS_AT) &&
                 ((pos_ext == '0) || (pos_ext > fill_ext + CMP_W'(1)));
      del_bad  = (req_func == FUNC_DEL_AT) &&
                 ((pos_ext == '0) || (pos_ext > fill_ext));
      case (req_func)
         FUNC_INS_HEAD: ins_idx = '0;
         FUNC_INS_TAIL: ins_idx = fill_ff;
         default:       ins_idx = pos_idx;
      endcase
      case (req_func)
         FUNC_DEL_HEAD: del_idx = '0;
         FUNC_DEL_TAIL: del_idx = fill_ff - CNT_W'(1);
         default:       del_idx = pos_idx;
      endcase
      do_ins = cmd.exec && is_ins && !is_full && !ins_bad;
      do_del = cmd.exec && is_del && !is_empty && !del_bad;
      if (is_ins && is_full)       op_status = STAT_FULL;
      else if (is_del && is_empty) op_status = STAT_EMPTY;
      else if (ins_bad || del_bad) op_status = STAT_BADPOS;
      else                         op_status = STAT_OK;
   end

   // cell chain: each cell keeps its value, takes a neighbor or takes the new value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_ins && (CNT_W'(i) >= ins_idx)) begin
            if (CNT_W'(i) == ins_idx) cells_in[i] = req_value;
            else                      cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else if (do_del && (CNT_W'(i) >= del_idx) && (i < DEPTH - 1)) begin
            cells_in[i] = cells_ff[i + 1];
         end
      end
      if (do_ins)      fill_in = fill_ff + CNT_W'(1);
      else if (do_del) fill_in = fill_ff - CNT_W'(1);
      else             fill_in = fill_ff;
   end

   // controller status
   always_comb begin
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.dump_more = (req_func == FUNC_DUMP) && (fill_ff > CNT_W'(1));
      sts.dump_last = (CNT_W'(idx_ff) == fill_ff - CNT_W'(1));
   end

   // output register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_evalid_in = rsp_evalid_ff;
      rsp_last_in   = rsp_last_ff;
      idx_in        = idx_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(fill_in);
         if (req_func == FUNC_DUMP && !is_empty) begin
            rsp_status_in = STAT_OK;
            rsp_value_in  = cells_ff[0];
            rsp_evalid_in = 1'b1;
            rsp_last_in   = (fill_ff == CNT_W'(1));
            idx_in        = IDX_W'(1);
         end else begin
            rsp_status_in = (req_func == FUNC_DUMP) ? STAT_EMPTY : op_status;
            rsp_value_in  = '0;
            rsp_evalid_in = 1'b0;
            rsp_last_in   = 1'b1;
         end
      end else if (cmd.dump_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_OK;
         rsp_count_in  = COUNT_W'(fill_ff);
         rsp_value_in  = cells_ff[idx_ff];
         rsp_evalid_in = 1'b1;
         rsp_last_in   = sts.dump_last;
         idx_in        = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff      <= cells_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_evalid_ff <= rsp_evalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_element_valid = rsp_evalid_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### rtl/ple_chk.sv
module ple_chk
   import ple_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [FUNC_W-1:0]         req_func,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STAT_W-1:0]         rsp_status,
   input logic [COUNT_W-1:0]        rsp_element_count,
   input logic signed [DATA_W-1:0]  rsp_element_value,
   input logic                      rsp_element_valid,
   input logic                      rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_value) &&
                                  $stable(rsp_last))
      else $error("result beat changed while stalled");

   // any request but a dump answers with one final beat in the next cycle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func != FUNC_DUMP) |=>
         rsp_valid && rsp_last && !rsp_element_valid)
      else $error("missing single result beat");

   // element beats always carry ok status
   a_elem_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_valid |-> rsp_status == STAT_OK)
      else $error("element beat with bad status");

   // count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= COUNT_W'(DEPTH))
      else $error("element count above capacity");

   // no new request while a dump still has beats to come
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during dump");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_element_count (rsp_element_count),
   .rsp_element_value (rsp_element_value),
   .rsp_element_valid (rsp_element_valid),
   .rsp_last          (rsp_last)
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ple_pkg::*;

   // func code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;

   localparam int N_DIRECTED   = 21;
   localparam int RANDOM_ITEMS = 100;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   // one result beat
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] value;
      logic                     element_valid;
      logic                     last;
   } list_beat_type;

   // one directed request; fixed rows carry their single result inline
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic                     fixed;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
   } list_case_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]       rsp_element_count;
   logic signed [DATA_W-1:0] rsp_element_value;
   logic                     rsp_element_valid;
   logic                     rsp_last;

   // shadow list and the beats it still owes
   logic signed [DATA_W-1:0] shadow_cells [DEPTH];
   int                       shadow_fill = 0;
   list_beat_type            step_beats [$];
   list_beat_type            list_beats_due [$];
   int                       error_count = 0;

   list_case_type            directed_cases [N_DIRECTED];

   positional_list_engine uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_element_value (rsp_element_value),
      .rsp_element_valid (rsp_element_valid),
      .rsp_last          (rsp_last)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic void add_beat(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] v,
                                    logic ev, logic lst);
      list_beat_type b;
      b.status        = st;
      b.count         = COUNT_W'(shadow_fill);
      b.value         = v;
      b.element_valid = ev;
      b.last          = lst;
      step_beats.push_back(b);
   endfunction

   // run one request on the shadow list, leaving its beats in step_beats
   function automatic void apply_list_request(logic [FUNC_W-1:0] f,
                                              logic signed [DATA_W-1:0] v,
                                              logic [POS_W-1:0] p);
      logic [STAT_W-1:0] st;
      int slot;
      int i;
      step_beats.delete();
      st = STAT_OK;
      case (f)
         FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_INS_AT: begin
            // full wins over a bad position
            if (shadow_fill >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               if (f == FUNC_INS_HEAD) slot = 0;
               else if (f == FUNC_INS_TAIL) slot = shadow_fill;
               else if (int'(p) < 1 || int'(p) > shadow_fill + 1) slot = -1;
               else slot = int'(p) - 1;
               if (slot < 0) begin
                  st = STAT_BADPOS;
               end else begin
                  for (i = shadow_fill; i > slot; i--) shadow_cells[i] = shadow_cells[i-1];
                  shadow_cells[slot] = v;
                  shadow_fill++;
               end
            end
         end
         FUNC_DEL_HEAD, FUNC_DEL_TAIL, FUNC_DEL_AT: begin
            // empty wins over a bad position
            if (shadow_fill == 0) begin
               st = STAT_EMPTY;
            end else begin
               if (f == FUNC_DEL_HEAD) slot = 0;
               else if (f == FUNC_DEL_TAIL) slot = shadow_fill - 1;
               else if (int'(p) < 1 || int'(p) > shadow_fill) slot = -1;
               else slot = int'(p) - 1;
               if (slot < 0) begin
                  st = STAT_BADPOS;
               end else begin
                  for (i = slot; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
                  shadow_fill--;
               end
            end
         end
         FUNC_DUMP: begin
            if (shadow_fill == 0) begin
               add_beat(STAT_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < shadow_fill; i++)
                  add_beat(STAT_OK, shadow_cells[i], 1'b1, i == shadow_fill - 1);
            end
            return;
         end
         default: ;
      endcase
      add_beat(st, '0, 1'b0, 1'b1);
   endfunction

   // offer one request beat; on acceptance queue the beats it owes
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                               input logic [POS_W-1:0] p, input logic fixed,
                               input logic [STAT_W-1:0] st, input logic [COUNT_W-1:0] cnt);
      int gap;
      list_beat_type b;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= f;
      req_value    <= v;
      req_position <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
      apply_list_request(f, v, p);
      if (fixed) begin
         b.status        = st;
         b.count         = cnt;
         b.value         = '0;
         b.element_valid = 1'b0;
         b.last          = 1'b1;
         list_beats_due.push_back(b);
      end else begin
         foreach (step_beats[i]) list_beats_due.push_back(step_beats[i]);
      end
      @(negedge clock);
   endtask

   // hold the sender off until every owed beat is in
   task automatic drain_list();
      req_valid <= 1'b0;
      @(negedge clock);
      while (list_beats_due.size() != 0) @(negedge clock);
   endtask

   // request side
   initial begin : req_source
      logic grow;
      logic [FUNC_W-1:0] f;
      logic signed [DATA_W-1:0] v;
      logic [POS_W-1:0] p;
      int r;
      int top;
      directed_cases = '{
         '{FUNC_DUMP,     32'sd0,          5'd0,  1'b1, STAT_EMPTY,  5'd0},
         '{FUNC_DEL_HEAD, 32'sd0,          5'd0,  1'b1, STAT_EMPTY,  5'd0},
         '{FUNC_DEL_TAIL, 32'sd0,          5'd0,  1'b1, STAT_EMPTY,  5'd0},
         '{FUNC_DEL_AT,   32'sd0,          5'd1,  1'b1, STAT_EMPTY,  5'd0},
         '{FUNC_INS_AT,   32'sd7,          5'd0,  1'b1, STAT_BADPOS, 5'd0},
         '{FUNC_INS_AT,   32'sd7,          5'd2,  1'b1, STAT_BADPOS, 5'd0},
         '{FUNC_INS_HEAD, 32'sh5A5A_A5A5,  5'd0,  1'b1, STAT_OK,     5'd1},
         '{FUNC_DEL_TAIL, 32'sd0,          5'd0,  1'b1, STAT_OK,     5'd0},
         '{FUNC_INS_TAIL, VAL_MIN,         5'd31, 1'b1, STAT_OK,     5'd1},
         '{FUNC_INS_AT,   -32'sd1,         5'd1,  1'b0, STAT_OK,     5'd0},
         '{FUNC_INS_AT,   VAL_MAX,         5'd3,  1'b0, STAT_OK,     5'd0},
         '{FUNC_DEL_AT,   32'sd0,          5'd31, 1'b1, STAT_BADPOS, 5'd3},
         '{FUNC_DEL_AT,   32'sd0,          5'd0,  1'b1, STAT_BADPOS, 5'd3},
         '{FUNC_DEL_AT,   32'sd0,          5'd4,  1'b1, STAT_BADPOS, 5'd3},
         '{FUNC_INS_AT,   32'sd0,          5'd31, 1'b1, STAT_BADPOS, 5'd3},
         '{FUNC_DUMP,     32'sd0,          5'd0,  1'b0, STAT_OK,     5'd0},
         '{FUNC_SPARE,    -32'sd1,         5'd31, 1'b1, STAT_OK,     5'd3},
         '{FUNC_DEL_AT,   32'sd0,          5'd2,  1'b0, STAT_OK,     5'd0},
         '{FUNC_DEL_HEAD, 32'sd0,          5'd0,  1'b0, STAT_OK,     5'd0},
         '{FUNC_DUMP,     32'sd0,          5'd0,  1'b0, STAT_OK,     5'd0},
         '{FUNC_DEL_AT,   32'sd0,          5'd1,  1'b1, STAT_OK,     5'd0}
      };
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_cases[i])
         send_request(directed_cases[i].func, directed_cases[i].value,
                      directed_cases[i].position, directed_cases[i].fixed,
                      directed_cases[i].status, directed_cases[i].count);
      drain_list();

      // random: swing the list between empty and full
      grow = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (grow && shadow_fill == DEPTH) begin
            // every insert kind bounces off a full list, then a full-length dump
            send_request(FUNC_INS_HEAD, $urandom, POS_W'($urandom_range(0, 31)), 1'b0,
                         STAT_OK, '0);
            send_request(FUNC_INS_TAIL, $urandom, POS_W'($urandom_range(0, 31)), 1'b0,
                         STAT_OK, '0);
            send_request(FUNC_INS_AT, $urandom, POS_W'($urandom_range(0, 31)), 1'b0,
                         STAT_OK, '0);
            send_request(FUNC_DUMP, $urandom, POS_W'($urandom_range(0, 31)), 1'b0,
                         STAT_OK, '0);
            grow = 1'b0;
         end
         if (!grow && shadow_fill == 0) grow = 1'b1;
         if (n == RANDOM_ITEMS / 2) drain_list();

         r = $urandom_range(0, 99);
         if (r < 8) begin
            f = FUNC_DUMP;
         end else if (r < 11) begin
            f = FUNC_SPARE;
         end else if (grow ? (r < 75) : (r < 35)) begin
            case ($urandom_range(0, 2))
               0: f = FUNC_INS_HEAD;
               1: f = FUNC_INS_TAIL;
               default: f = FUNC_INS_AT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0: f = FUNC_DEL_HEAD;
               1: f = FUNC_DEL_TAIL;
               default: f = FUNC_DEL_AT;
            endcase
         end

         // mostly legal positions, some anywhere in the field
         top = (f == FUNC_DEL_AT) ? shadow_fill : shadow_fill + 1;
         if (top < 1) top = 1;
         if ($urandom_range(0, 99) < 80) p = POS_W'($urandom_range(1, top));
         else p = POS_W'($urandom_range(0, 31));

         case ($urandom_range(0, 19))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            3: v = -32'sd1;
            default: v = $urandom;
         endcase

         send_request(f, v, p, 1'b0, STAT_OK, '0);
      end
      req_valid <= 1'b0;

      // wrap up
      while (list_beats_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && list_beats_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side: random back-pressure, a long hold every so often
   initial begin : rsp_sink
      int gap;
      int taken;
      taken = 0;
      @(negedge clock);
      forever begin
         gap = (taken % 64 == 40) ? 80 : pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         taken++;
         @(negedge clock);
      end
   end

   // compare each result beat with the oldest one owed
   always @(posedge clock) begin : rsp_check
      list_beat_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (list_beats_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result beat: st=%0d cnt=%0d val=%0d ev=%0d last=%0d",
                        rsp_status, rsp_element_count, rsp_element_value,
                        rsp_element_valid, rsp_last);
         end else begin
            due = list_beats_due.pop_front();
            if (rsp_status !== due.status || rsp_element_count !== due.count ||
                rsp_element_value !== due.value || rsp_element_valid !== due.element_valid ||
                rsp_last !== due.last) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch at %0t: exp st=%0d cnt=%0d val=%0d ev=%0d last=%0d,",
                            " got st=%0d cnt=%0d val=%0d ev=%0d last=%0d"},
                           $realtime, due.status, due.count, due.value, due.element_valid,
                           due.last, rsp_status, rsp_element_count, rsp_element_value,
                           rsp_element_valid, rsp_last);
            end
         end
      end
   end

endmodule
